// ===== rtl/grw_pkg.sv =====
package grw_pkg;

    localparam int MAX_RES_DEF   = 255;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [30:0] T_SAT = 31'h7FFF_FFFF;

    localparam logic [1:0] ST_CELL   = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_LEFT   = 2'd2;
    localparam logic [1:0] ST_NO_RAY = 2'd3;

    localparam logic [2:0] REG_CELL_SIZE_X = 3'd0;
    localparam logic [2:0] REG_CELL_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_GRID_MIN_X  = 3'd3;
    localparam logic [2:0] REG_GRID_MIN_Y  = 3'd4;
    localparam logic [2:0] REG_GRID_MIN_Z  = 3'd5;
    localparam logic [2:0] REG_GRID_RES    = 3'd6;

    localparam logic [1:0] PH_CELL  = 2'd0;
    localparam logic [1:0] PH_TIME  = 2'd1;
    localparam logic [1:0] PH_DELTA = 2'd2;

    localparam logic [1:0] AXIS_PICK [8] = '{2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0};

    // smallest boundary wins, ties go to the higher axis
    function automatic logic [1:0] nearest_axis(input logic [30:0] t0,
                                                input logic [30:0] t1,
                                                input logic [30:0] t2);
        logic [2:0] k;
        k = {t0 < t1, t0 < t2, t1 < t2};
        return AXIS_PICK[k];
    endfunction

endpackage

// ===== rtl/grw_req_if.sv =====
interface grw_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        t_entry;
    logic [30:0]        hit_t;

    modport source (output valid, req_type, org_x, org_y, org_z, dir_x, dir_y, dir_z,
                    t_entry, hit_t, input ready);
    modport sink (input valid, req_type, org_x, org_y, org_z, dir_x, dir_y, dir_z,
                  t_entry, hit_t, output ready);
endinterface

// ===== rtl/grw_rsp_if.sv =====
interface grw_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [7:0]  cell_z;
    logic [23:0] cell_index;
    logic [30:0] t_cell_exit;
    logic [1:0]  status;

    modport source (output valid, cell_x, cell_y, cell_z, cell_index, t_cell_exit, status,
                    input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, cell_index, t_cell_exit, status,
                  output ready);
endinterface

// ===== rtl/grid_ray_cell_walker_unit.sv =====
// sequence: a continue transaction goes from accept through S_EMIT to the result register; a start
// transaction runs per axis a multiply, an offset and up to three 33-step restoring divisions on
// the shared divider (cell, boundary time, delta), axes in turn; a saturating division is skipped,
// a negative offset skips the cell division and a zero direction skips the other two
// throughput: one transaction at a time, next accepted once the result register is free
// reset: rst_n asynchronous active low, clears ray state, config to defaults, no result
module grid_ray_cell_walker_unit #(
    parameter int MAX_RES   = grw_pkg::MAX_RES_DEF,
    parameter int FRAC_BITS = grw_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    grw_req_if.sink     req,
    grw_rsp_if.source   rsp
);
    import grw_pkg::*;

    localparam int DW = 57 + FRAC_BITS;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MUL    = 10'b00_0000_0010,
        S_RCO    = 10'b00_0000_0100,
        S_CSTART = 10'b00_0000_1000,
        S_DIV    = 10'b00_0001_0000,
        S_BOUND  = 10'b00_0010_0000,
        S_TSTART = 10'b00_0100_0000,
        S_TNB    = 10'b00_1000_0000,
        S_DELTA  = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    // config registers
    logic [30:0]        size_reg [3];
    logic signed [31:0] min_reg  [3];
    logic [23:0]        res_cfg_reg;
    logic [15:0]        rxry_reg;

    // ray state
    logic        ray_active_reg;
    logic [7:0]  cur_cell_reg [3];
    logic [30:0] tnb_reg [3];
    logic [30:0] td_reg  [3];
    logic        step_neg_reg [3];

    // start working registers
    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [30:0]        te_reg;
    logic [1:0]         axis_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] rco_reg;
    logic signed [63:0] dist_reg;
    logic               dist_neg_reg;
    logic               cz_reg;
    logic [1:0]         status_reg;

    // shared divider
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [32:0]   q_reg;
    logic [5:0]    cnt_reg;
    logic          sat_reg;
    logic [1:0]    phase_reg;

    logic out_valid_reg;
    logic [7:0]  ox_reg, oy_reg, oz_reg;
    logic [23:0] oidx_reg;
    logic [30:0] otx_reg;
    logic [1:0]  ost_reg;

    logic [7:0] res_ax [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            res_ax[k] = res_cfg_reg[8*k +: 8];
            if (res_ax[k] == 8'd0)
                res_ax[k] = 8'd1;
            else if (32'(res_ax[k]) > MAX_RES)
                res_ax[k] = 8'(MAX_RES);
        end
    end

    logic wr_en;
    logic [2:0] ridx;
    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        case (ridx)
            REG_CELL_SIZE_X: prdata = {1'b0, size_reg[0]};
            REG_CELL_SIZE_Y: prdata = {1'b0, size_reg[1]};
            REG_CELL_SIZE_Z: prdata = {1'b0, size_reg[2]};
            REG_GRID_MIN_X:  prdata = min_reg[0];
            REG_GRID_MIN_Y:  prdata = min_reg[1];
            REG_GRID_MIN_Z:  prdata = min_reg[2];
            REG_GRID_RES:    prdata = {8'd0, res_cfg_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // axis operands
    logic signed [31:0] dir_sel;
    logic [30:0]        sz_eff;
    logic [31:0]        absd;
    logic signed [31:0] te_s;
    logic signed [63:0] prod_next;
    logic signed [63:0] rco_next;
    assign dir_sel   = dir_reg[axis_reg];
    assign sz_eff    = (size_reg[axis_reg] == 31'd0) ? 31'd1 : size_reg[axis_reg];
    assign absd      = dir_sel[31] ? 32'(-dir_sel) : dir_sel;
    assign te_s      = {1'b0, te_reg};
    assign prod_next = dir_sel * te_s;
    assign rco_next  = 64'(org_reg[axis_reg]) + (prod_reg >>> FRAC_BITS)
                     - 64'(min_reg[axis_reg]);

    // first cell, clamped
    logic [7:0]  res_a;
    logic [7:0]  c_sel;
    logic [8:0]  c_bnd;
    logic [39:0] bound;
    logic signed [63:0] dist_next;
    logic [63:0] absdist;
    assign res_a = res_ax[axis_reg];
    always_comb
    begin
        if (cz_reg)
            c_sel = 8'd0;
        else if (sat_reg || q_reg >= 33'(res_a))
            c_sel = res_a - 8'd1;
        else
            c_sel = q_reg[7:0];
    end
    assign c_bnd     = dir_sel[31] ? {1'b0, c_sel} : {1'b0, c_sel} + 9'd1;
    assign bound     = c_bnd * sz_eff;
    assign dist_next = $signed({24'd0, bound}) - rco_reg;
    assign absdist   = dist_reg[63] ? 64'(-dist_reg) : 64'(dist_reg);

    // divider load mux
    logic [DW-1:0] div_n;
    logic [31:0]   div_v;
    logic [1:0]    div_ph;
    logic          div_sat;
    always_comb
    begin
        case (state_reg)
            S_CSTART:
            begin
                div_n  = DW'($unsigned(rco_reg));
                div_v  = {1'b0, sz_eff};
                div_ph = PH_CELL;
            end
            S_TSTART:
            begin
                div_n  = DW'(absdist) << FRAC_BITS;
                div_v  = absd;
                div_ph = PH_TIME;
            end
            default:
            begin
                div_n  = DW'(sz_eff) << FRAC_BITS;
                div_v  = absd;
                div_ph = PH_DELTA;
            end
        endcase
    end
    assign div_sat = div_n >= (DW'(div_v) << 33);

    function automatic state_t ret_state(input logic [1:0] ph);
        case (ph)
            PH_CELL: return S_BOUND;
            PH_TIME: return S_TNB;
            default: return S_DELTA;
        endcase
    endfunction

    // boundary time and delta
    logic signed [34:0] tsum;
    logic               tneg;
    logic [30:0]        tnb_val;
    logic [30:0]        td_val;
    assign tneg = dist_neg_reg ^ dir_sel[31];
    assign tsum = tneg ? $signed({4'd0, te_reg}) - $signed({2'd0, q_reg})
                       : $signed({4'd0, te_reg}) + $signed({2'd0, q_reg});
    always_comb
    begin
        if (sat_reg)
            tnb_val = tneg ? 31'd0 : T_SAT;
        else if (tsum < 0)
            tnb_val = 31'd0;
        else if (tsum > $signed({4'd0, T_SAT}))
            tnb_val = T_SAT;
        else
            tnb_val = tsum[30:0];
        td_val = (sat_reg || q_reg > {2'd0, T_SAT}) ? T_SAT : q_reg[30:0];
    end

    // continue step
    logic [1:0]  near_a;
    logic [31:0] tadd;
    logic [30:0] tstep;
    assign near_a = nearest_axis(tnb_reg[0], tnb_reg[1], tnb_reg[2]);
    assign tadd   = {1'b0, tnb_reg[near_a]} + {1'b0, td_reg[near_a]};
    assign tstep  = (tadd > {1'b0, T_SAT}) ? T_SAT : tadd[30:0];

    logic accept;
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    logic [23:0] idx_val;
    assign idx_val = 24'(cur_cell_reg[0]) + 24'(cur_cell_reg[1]) * 24'(res_ax[0])
                   + 24'(cur_cell_reg[2]) * 24'(rxry_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                size_reg[k] <= 31'd65536;
                min_reg[k]  <= 32'sd0;
            end
            res_cfg_reg <= 24'd65793;
            rxry_reg    <= 16'd1;
        end
        else
        begin
            rxry_reg <= 16'(res_ax[0]) * 16'(res_ax[1]);
            if (wr_en)
            begin
                case (ridx)
                    REG_CELL_SIZE_X: size_reg[0] <= pwdata[30:0];
                    REG_CELL_SIZE_Y: size_reg[1] <= pwdata[30:0];
                    REG_CELL_SIZE_Z: size_reg[2] <= pwdata[30:0];
                    REG_GRID_MIN_X:  min_reg[0]  <= pwdata;
                    REG_GRID_MIN_Y:  min_reg[1]  <= pwdata;
                    REG_GRID_MIN_Z:  min_reg[2]  <= pwdata;
                    REG_GRID_RES:    res_cfg_reg <= pwdata[23:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ray_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            axis_reg       <= 2'd0;
            for (int k = 0; k < 3; k++)
            begin
                cur_cell_reg[k] <= 8'd0;
                tnb_reg[k]      <= 31'd0;
                td_reg[k]       <= 31'd0;
                step_neg_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!req.req_type)
                        begin
                            org_reg[0] <= req.org_x;
                            org_reg[1] <= req.org_y;
                            org_reg[2] <= req.org_z;
                            dir_reg[0] <= req.dir_x;
                            dir_reg[1] <= req.dir_y;
                            dir_reg[2] <= req.dir_z;
                            te_reg     <= req.t_entry;
                            axis_reg   <= 2'd0;
                            state_reg  <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                            if (!ray_active_reg)
                                status_reg <= ST_NO_RAY;
                            else if (req.hit_t < tnb_reg[near_a])
                            begin
                                status_reg     <= ST_HIT;
                                ray_active_reg <= 1'b0;
                            end
                            else if (step_neg_reg[near_a] ? (cur_cell_reg[near_a] == 8'd0)
                                     : ({1'b0, cur_cell_reg[near_a]} + 9'd1
                                        >= {1'b0, res_ax[near_a]}))
                            begin
                                status_reg     <= ST_LEFT;
                                ray_active_reg <= 1'b0;
                            end
                            else
                            begin
                                status_reg <= ST_CELL;
                                cur_cell_reg[near_a] <= step_neg_reg[near_a]
                                    ? cur_cell_reg[near_a] - 8'd1
                                    : cur_cell_reg[near_a] + 8'd1;
                                tnb_reg[near_a] <= tstep;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_RCO;
                end
                S_RCO:
                begin
                    rco_reg   <= rco_next;
                    state_reg <= S_CSTART;
                end
                S_CSTART, S_TSTART:
                begin
                    // negative offset from the grid corner clamps to cell zero
                    if (state_reg == S_CSTART && rco_reg[63])
                    begin
                        cz_reg    <= 1'b1;
                        state_reg <= S_BOUND;
                    end
                    else
                    begin
                        cz_reg    <= 1'b0;
                        rem_reg   <= div_n;
                        dvs_reg   <= DW'(div_v) << 32;
                        q_reg     <= 33'd0;
                        cnt_reg   <= 6'd32;
                        sat_reg   <= div_sat;
                        phase_reg <= div_ph;
                        state_reg <= div_sat ? ret_state(div_ph) : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_reg >= dvs_reg)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                        q_reg   <= {q_reg[31:0], 1'b1};
                    end
                    else
                        q_reg <= {q_reg[31:0], 1'b0};
                    dvs_reg <= dvs_reg >> 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= ret_state(phase_reg);
                end
                S_BOUND:
                begin
                    cur_cell_reg[axis_reg] <= c_sel;
                    step_neg_reg[axis_reg] <= dir_sel[31];
                    dist_reg     <= dist_next;
                    dist_neg_reg <= dist_next[63];
                    if (dir_sel == 32'sd0)
                    begin
                        tnb_reg[axis_reg] <= T_SAT;
                        td_reg[axis_reg]  <= T_SAT;
                        if (axis_reg == 2'd2)
                        begin
                            ray_active_reg <= 1'b1;
                            status_reg     <= ST_CELL;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                        state_reg <= S_TSTART;
                end
                S_TNB:
                begin
                    tnb_reg[axis_reg] <= tnb_val;
                    rem_reg   <= div_n;
                    dvs_reg   <= DW'(div_v) << 32;
                    q_reg     <= 33'd0;
                    cnt_reg   <= 6'd32;
                    sat_reg   <= div_sat;
                    phase_reg <= div_ph;
                    state_reg <= div_sat ? ret_state(div_ph) : S_DIV;
                end
                S_DELTA:
                begin
                    td_reg[axis_reg] <= td_val;
                    if (axis_reg == 2'd2)
                    begin
                        ray_active_reg <= 1'b1;
                        status_reg     <= ST_CELL;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    ost_reg       <= status_reg;
                    if (status_reg == ST_NO_RAY)
                    begin
                        ox_reg   <= 8'd0;
                        oy_reg   <= 8'd0;
                        oz_reg   <= 8'd0;
                        oidx_reg <= 24'd0;
                        otx_reg  <= 31'd0;
                    end
                    else
                    begin
                        ox_reg   <= cur_cell_reg[0];
                        oy_reg   <= cur_cell_reg[1];
                        oz_reg   <= cur_cell_reg[2];
                        oidx_reg <= idx_val;
                        otx_reg  <= tnb_reg[near_a];
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.cell_x      = ox_reg;
    assign rsp.cell_y      = oy_reg;
    assign rsp.cell_z      = oz_reg;
    assign rsp.cell_index  = oidx_reg;
    assign rsp.t_cell_exit = otx_reg;
    assign rsp.status      = ost_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |=> rsp.valid)
        else $error("emit did not raise valid");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> axis_reg != 2'd3)
        else $error("axis counter out of range");

endmodule

// ===== tb/walk_monitor.sv =====
`timescale 1ns / 100ps

module walk_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    grw_req_if          req,
    grw_rsp_if          rsp,
    output int          fails,
    output int          pending
);
    import grw_pkg::*;

    localparam longint SAT   = 64'h7FFF_FFFF;
    localparam longint HUGE  = 64'h100_0000_0000;
    localparam int     FRAC  = FRAC_BITS_DEF;

    typedef struct {
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [7:0]  cz;
        logic [23:0] idx;
        logic [30:0] t_exit;
        logic [1:0]  st;
    } cell_result_t;

    cell_result_t cell_q[$];

    // shadow of the register file
    logic [30:0] size_reg [3];
    logic [31:0] min_reg [3];
    logic [23:0] res_reg;

    // shadow of the walk state
    bit          walking;
    logic [7:0]  cur [3];
    longint      t_bound [3];
    longint      t_step [3];
    bit          go_down [3];

    function automatic longint axis_res(int a);
        longint r;
        r = res_reg[8*a +: 8];
        if (r == 0)
            r = 1;
        if (r > MAX_RES_DEF)
            r = MAX_RES_DEF;
        return r;
    endfunction

    function automatic longint sat_time(longint t);
        if (t < 0)
            return 0;
        if (t > SAT)
            return SAT;
        return t;
    endfunction

    // signed span * 2^F / dir, magnitude truncated and capped
    function automatic longint cross_time(longint span, longint dir);
        bit neg;
        longint ud, uv, q, r, mag;
        neg = (span < 0) != (dir < 0);
        ud = span < 0 ? -span : span;
        uv = dir < 0 ? -dir : dir;
        q = ud / uv;
        r = ud % uv;
        if (q >= 64'h8000_0000)
            mag = HUGE;
        else
            mag = (q << FRAC) + ((r << FRAC) / uv);
        if (mag > HUGE)
            mag = HUGE;
        return neg ? -mag : mag;
    endfunction

    function automatic int closest_axis();
        if (t_bound[0] < t_bound[1] && t_bound[0] < t_bound[2])
            return 0;
        if (t_bound[1] < t_bound[2])
            return 1;
        return 2;
    endfunction

    function automatic cell_result_t cell_report(logic [1:0] st);
        cell_result_t c;
        longint rx, ry;
        rx = axis_res(0);
        ry = axis_res(1);
        c.cx = cur[0];
        c.cy = cur[1];
        c.cz = cur[2];
        c.idx = 24'(longint'(cur[0]) + longint'(cur[1]) * rx + longint'(cur[2]) * rx * ry);
        c.t_exit = 31'(t_bound[closest_axis()]);
        c.st = st;
        return c;
    endfunction

    function automatic cell_result_t start_ray(logic signed [31:0] org [3],
                                               logic signed [31:0] dir [3],
                                               logic [30:0] te_in);
        longint te, o, d, sz, res, rco, c, bnd;
        te = te_in;
        for (int i = 0; i < 3; i++)
        begin
            o = org[i];
            d = dir[i];
            sz = size_reg[i] == 0 ? 1 : size_reg[i];
            res = axis_res(i);
            rco = o + ((d * te) >>> FRAC) - longint'($signed(min_reg[i]));
            c = rco / sz;
            if (rco % sz != 0 && rco < 0)
                c = c - 1;
            if (c < 0)
                c = 0;
            if (c > res - 1)
                c = res - 1;
            cur[i] = 8'(c);
            go_down[i] = d < 0;
            bnd = d < 0 ? c * sz : (c + 1) * sz;
            if (d == 0)
            begin
                t_bound[i] = SAT;
                t_step[i] = SAT;
            end
            else
            begin
                t_bound[i] = sat_time(te + cross_time(bnd - rco, d));
                t_step[i] = sat_time((sz << FRAC) / (d < 0 ? -d : d));
            end
        end
        walking = 1;
        return cell_report(ST_CELL);
    endfunction

    function automatic cell_result_t advance_ray(logic [30:0] hit);
        cell_result_t c;
        int a;
        if (!walking)
        begin
            c = '{default: '0};
            c.st = ST_NO_RAY;
            return c;
        end
        a = closest_axis();
        if (longint'(hit) < t_bound[a])
        begin
            walking = 0;
            return cell_report(ST_HIT);
        end
        if (go_down[a])
        begin
            if (cur[a] == 0)
            begin
                walking = 0;
                return cell_report(ST_LEFT);
            end
            cur[a] = cur[a] - 8'd1;
        end
        else
        begin
            if (longint'(cur[a]) + 1 >= axis_res(a))
            begin
                walking = 0;
                return cell_report(ST_LEFT);
            end
            cur[a] = cur[a] + 8'd1;
        end
        t_bound[a] = sat_time(t_bound[a] + t_step[a]);
        return cell_report(ST_CELL);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        cell_result_t got;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        if (!rst_n)
        begin
            size_reg = '{31'd65536, 31'd65536, 31'd65536};
            min_reg = '{32'd0, 32'd0, 32'd0};
            res_reg = 24'd65793;
            walking = 0;
            for (int i = 0; i < 3; i++)
            begin
                cur[i] = '0;
                t_bound[i] = 0;
                t_step[i] = 0;
                go_down[i] = 0;
            end
            cell_q.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CELL_SIZE_X: size_reg[0] = pwdata[30:0];
                    REG_CELL_SIZE_Y: size_reg[1] = pwdata[30:0];
                    REG_CELL_SIZE_Z: size_reg[2] = pwdata[30:0];
                    REG_GRID_MIN_X:  min_reg[0] = pwdata;
                    REG_GRID_MIN_Y:  min_reg[1] = pwdata;
                    REG_GRID_MIN_Z:  min_reg[2] = pwdata;
                    REG_GRID_RES:    res_reg = pwdata[23:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (cell_q.size() == 0)
                begin
                    $error("unexpected result transaction, status %0d", rsp.status);
                    fails++;
                end
                else
                begin
                    want = cell_q.pop_front();
                    if (rsp.cell_x !== want.cx)
                    begin
                        $error("cell_x expected %0d actual %0d", want.cx, rsp.cell_x);
                        fails++;
                    end
                    if (rsp.cell_y !== want.cy)
                    begin
                        $error("cell_y expected %0d actual %0d", want.cy, rsp.cell_y);
                        fails++;
                    end
                    if (rsp.cell_z !== want.cz)
                    begin
                        $error("cell_z expected %0d actual %0d", want.cz, rsp.cell_z);
                        fails++;
                    end
                    if (rsp.cell_index !== want.idx)
                    begin
                        $error("cell_index expected %0d actual %0d", want.idx, rsp.cell_index);
                        fails++;
                    end
                    if (rsp.t_cell_exit !== want.t_exit)
                    begin
                        $error("t_cell_exit expected %0h actual %0h",
                               want.t_exit, rsp.t_cell_exit);
                        fails++;
                    end
                    if (rsp.status !== want.st)
                    begin
                        $error("status expected %0d actual %0d", want.st, rsp.status);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == 1'b0)
                begin
                    org = '{req.org_x, req.org_y, req.org_z};
                    dir = '{req.dir_x, req.dir_y, req.dir_z};
                    got = start_ray(org, dir, req.t_entry);
                end
                else
                    got = advance_ray(req.hit_t);
                cell_q = {cell_q, got};
            end
            pending = cell_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import grw_pkg::*;

    localparam logic [30:0] NO_HIT = 31'h7FFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fails;
    int          pending;

    grw_req_if req ();
    grw_rsp_if rsp ();

    grid_ray_cell_walker_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req),
        .rsp     (rsp)
    );

    walk_monitor mon (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .req     (req),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending)
    );

    // configuration the stimulus aims at
    longint cfg_size [3];
    longint cfg_min [3];
    longint cfg_res [3];
    bit     no_gaps;
    int     n_starts;
    int     n_conts;
    int     n_phases;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int stall;
        rsp.ready = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp.ready <= 0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1;
            do @(posedge clk); while (!(rsp.valid && rsp.ready));
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // stop offering transactions and wait until every result is out
    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid(longint sx, longint sy, longint sz, longint mx, longint my,
                            longint mz, logic [23:0] res);
        drain();
        reg_write(REG_CELL_SIZE_X, 32'(sx));
        reg_write(REG_CELL_SIZE_Y, 32'(sy));
        reg_write(REG_CELL_SIZE_Z, 32'(sz));
        reg_write(REG_GRID_MIN_X, 32'(mx));
        reg_write(REG_GRID_MIN_Y, 32'(my));
        reg_write(REG_GRID_MIN_Z, 32'(mz));
        reg_write(REG_GRID_RES, res);
        cfg_size = '{sx == 0 ? 1 : sx, sy == 0 ? 1 : sy, sz == 0 ? 1 : sz};
        cfg_min = '{mx, my, mz};
        for (int i = 0; i < 3; i++)
            cfg_res[i] = res[8*i +: 8] == 0 ? 1 : res[8*i +: 8];
        n_phases++;
    endtask

    // valid stays high across back-to-back transactions unless a random gap drops it first
    task automatic put_item(bit kind, logic signed [31:0] org [3], logic signed [31:0] dir [3],
                            logic [30:0] te, logic [30:0] hit);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1;
        req.req_type <= kind;
        req.org_x <= org[0];
        req.org_y <= org[1];
        req.org_z <= org[2];
        req.dir_x <= dir[0];
        req.dir_y <= dir[1];
        req.dir_z <= dir[2];
        req.t_entry <= te;
        req.hit_t <= hit;
        do @(posedge clk); while (!req.ready);
        if (kind)
            n_conts++;
        else
            n_starts++;
    endtask

    task automatic start_at(logic signed [31:0] o0, logic signed [31:0] o1,
                            logic signed [31:0] o2, logic signed [31:0] d0,
                            logic signed [31:0] d1, logic signed [31:0] d2, logic [30:0] te);
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        org = '{o0, o1, o2};
        dir = '{d0, d1, d2};
        put_item(1'b0, org, dir, te, 31'($urandom));
    endtask

    task automatic step_ray(logic [30:0] hit);
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        org = '{$urandom, $urandom, $urandom};
        dir = '{$urandom, $urandom, $urandom};
        put_item(1'b1, org, dir, 31'($urandom), hit);
    endtask

    task automatic noise_item();
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        org = '{$urandom, $urandom, $urandom};
        dir = '{$urandom, $urandom, $urandom};
        put_item(1'($urandom), org, dir, 31'($urandom), 31'($urandom));
    endtask

    // a start inside the grid followed by a walk of random length
    task automatic random_ray();
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        int steps;
        for (int i = 0; i < 3; i++)
        begin
            org[i] = 32'(cfg_min[i] + longint'($urandom_range(0, 32'hFFFF_FFFF))
                         % (cfg_res[i] * cfg_size[i]));
            case ($urandom_range(0, 7))
                0: dir[i] = 0;
                1: dir[i] = $urandom;
                default: dir[i] = $signed($urandom_range(0, 262144)) - 131072;
            endcase
        end
        put_item(1'b0, org, dir,
                 $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom_range(0, 131072)),
                 31'($urandom));
        steps = $urandom_range(0, 24);
        for (int s = 0; s < steps; s++)
            step_ray($urandom_range(0, 9) == 0 ? 31'($urandom) : NO_HIT);
    endtask

    task automatic random_phase(int items);
        int start_count;
        start_count = n_starts + n_conts;
        no_gaps = $urandom_range(0, 3) == 0;
        while (n_starts + n_conts - start_count < items)
        begin
            if ($urandom_range(0, 9) == 0)
                noise_item();
            else
                random_ray();
        end
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req.valid = 0;
        req.req_type = 0;
        req.org_x = 0;
        req.org_y = 0;
        req.org_z = 0;
        req.dir_x = 0;
        req.dir_y = 0;
        req.dir_z = 0;
        req.t_entry = 0;
        req.hit_t = 0;
        no_gaps = 0;
        n_starts = 0;
        n_conts = 0;
        n_phases = 0;
        cfg_size = '{65536, 65536, 65536};
        cfg_min = '{0, 0, 0};
        cfg_res = '{1, 1, 1};
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // reset grid: continue with no ray, zero direction, extremes
        step_ray(NO_HIT);
        start_at(0, 0, 0, 0, 0, 0, 0);
        step_ray(NO_HIT);
        step_ray(NO_HIT);
        start_at(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, -1,
                 31'h7FFF_FFFF);
        step_ray(31'd0);

        set_grid(65536, 65536, 65536, 0, 0, 0, 24'h08_08_08);
        start_at(32'h1_8000, 32'h2_4000, 32'h3_0000, 65536, 32768, -16384, 0);
        for (int i = 0; i < 6; i++)
            step_ray(NO_HIT);
        step_ray(31'd0);
        step_ray(NO_HIT);
        start_at(32'h7_8000, 32'h0_8000, 32'h4_0000, -65536, -65536, 0, 31'h1_0000);
        step_ray(NO_HIT);
        // new start drops the active ray
        start_at(0, 0, 0, 65536, 65536, 65536, 0);
        step_ray(31'h7FFF_FFFE);
        for (int i = 0; i < 4; i++)
            step_ray(NO_HIT);

        set_grid(1, 1, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FF_FF);
        random_phase(90);
        set_grid(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'h00_00_00);
        random_phase(40);
        set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -65536, 0, 65536, 24'h01_C8_03);
        random_phase(60);
        for (int p = 0; p < 6; p++)
        begin
            set_grid($urandom_range(4096, 262144), $urandom_range(4096, 262144),
                     $urandom_range(4096, 262144), $signed($urandom_range(0, 2097152)) - 1048576,
                     $signed($urandom_range(0, 2097152)) - 1048576,
                     $signed($urandom_range(0, 2097152)) - 1048576,
                     {8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
                      8'($urandom_range(1, 16))});
            random_phase(90);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d ray starts and %0d continue transactions over %0d grids",
                 n_starts, n_conts, n_phases + 1);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
